// ----- sv/fsp_pkg.sv -----
// Shared types, character codes and helpers for the format specifier field parser.
package fsp_pkg;

	localparam int unsigned NUM_BITS  = 16;
	localparam int unsigned MAX_FLAGS = 5;
	localparam int unsigned WIDE_W    = NUM_BITS + 4;
	localparam int unsigned CNT_W     = $clog2(MAX_FLAGS + 1);
	localparam int unsigned SLOT_W    = $clog2(MAX_FLAGS);

	localparam logic [NUM_BITS-1:0] SAT_MAX = '1;

	// Characters of interest
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_LO_L  = 8'h6c;
	localparam logic [7:0] CH_LO_H  = 8'h68;
	localparam logic [7:0] CH_LO_J  = 8'h6a;
	localparam logic [7:0] CH_LO_Z  = 8'h7a;
	localparam logic [7:0] CH_LO_T  = 8'h74;
	localparam logic [7:0] CH_UP_L  = 8'h4c;

	// Flag codes
	localparam logic [2:0] FLAG_NONE  = 3'd0;
	localparam logic [2:0] FLAG_MINUS = 3'd1;
	localparam logic [2:0] FLAG_PLUS  = 3'd2;
	localparam logic [2:0] FLAG_SPACE = 3'd3;
	localparam logic [2:0] FLAG_HASH  = 3'd4;
	localparam logic [2:0] FLAG_ZERO  = 3'd5;

	// Length modifier codes
	localparam logic [3:0] LEN_NONE = 4'd0;
	localparam logic [3:0] LEN_L    = 4'd1;
	localparam logic [3:0] LEN_H    = 4'd2;
	localparam logic [3:0] LEN_J    = 4'd3;
	localparam logic [3:0] LEN_Z    = 4'd4;
	localparam logic [3:0] LEN_T    = 4'd5;
	localparam logic [3:0] LEN_UL   = 4'd6;
	localparam logic [3:0] LEN_LL   = 4'd7;
	localparam logic [3:0] LEN_HH   = 4'd8;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} spec_beat_t;

	typedef struct packed {
		logic [2:0]  flag_first;
		logic [2:0]  flag_second;
		logic [2:0]  flag_third;
		logic [2:0]  flag_fourth;
		logic [2:0]  flag_fifth;
		logic [15:0] field_width;
		logic [15:0] precision;
		logic [3:0]  length_mod;
		logic [7:0]  conv_type;
	} result_beat_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// acc * 10 + digit, clamped at SAT_MAX
	function automatic logic [NUM_BITS-1:0] acc_digit(input logic [NUM_BITS-1:0] acc,
			input logic [7:0] c);
		logic [WIDE_W-1:0] ext;
		logic [WIDE_W-1:0] wide;
		ext  = {4'b0, acc};
		wide = (ext << 3) + (ext << 1) + WIDE_W'(c[3:0]);
		if (wide > {4'b0, SAT_MAX}) begin
			return SAT_MAX;
		end
		return wide[NUM_BITS-1:0];
	endfunction

endpackage

// ----- sv/fsp_if.sv -----
// Valid/ready channel interfaces for specifier characters and parsed results.
interface fsp_spec_if;
	import fsp_pkg::*;
	logic       valid;
	logic       ready;
	spec_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fsp_result_if;
	import fsp_pkg::*;
	logic         valid;
	logic         ready;
	result_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- sv/format_spec_field_parser_core.sv -----
// Printf conversion specifier parser: one character per beat, one result per specifier.
//
// Channels: spec carries one raw character per beat with last marking the
// conversion type; result carries the parsed flags, width, precision, length
// modifier and type, one beat per specifier.
// Latency: the result beat is valid the cycle after the last character is
// accepted. Throughput: one character per cycle while spec.ready is high; the running
// parse state (previous char, flag slots, accumulators) is updated in that same cycle.
// A single result register sits between the sides: spec stays ready while
// the result register is empty or being drained in the same cycle.
// When the receiver stalls with a result pending, spec.ready drops and
// the parse state holds until the result beat is taken.
// Reset clears the parse state and the result valid; every specifier
// starts from the empty state, and the state clears again after each result.
module format_spec_field_parser_core (
	input  logic                 clk,
	input  logic                 arst_n,
	fsp_spec_if.sink             spec,
	fsp_result_if.source         result
);
	import fsp_pkg::*;

	logic [7:0]          prev_q;
	logic [2:0]          slot_q [MAX_FLAGS];
	logic [CNT_W-1:0]    flag_cnt_q;
	logic [NUM_BITS-1:0] width_acc_q;
	logic [NUM_BITS-1:0] prec_acc_q;
	logic                prec_on_q;
	logic                skip_q;
	logic [3:0]          len_q;

	logic [7:0]          prev_n;
	logic [2:0]          slot_n [MAX_FLAGS];
	logic [CNT_W-1:0]    flag_cnt_n;
	logic [NUM_BITS-1:0] width_acc_n;
	logic [NUM_BITS-1:0] prec_acc_n;
	logic                prec_on_n;
	logic                skip_n;
	logic [3:0]          len_n;

	logic                out_v_q;
	result_beat_t        out_q;
	logic                accept;

	assign spec.ready   = !out_v_q || result.ready;
	assign accept       = spec.valid && spec.ready;
	assign result.valid = out_v_q;
	assign result.data  = out_q;

	always_comb begin
		logic [7:0] c;
		logic       dig;
		logic       pdig;
		logic [2:0] code;
		logic       hit;
		c    = spec.data.ch;
		dig  = is_digit(c);
		pdig = is_digit(prev_q);
		hit  = 1'b0;

		// flags
		case (c)
			CH_MINUS: code = FLAG_MINUS;
			CH_PLUS:  code = FLAG_PLUS;
			CH_SPACE: code = FLAG_SPACE;
			CH_HASH:  code = FLAG_HASH;
			CH_ZERO:  code = (!pdig && prev_q != CH_DOT) ? FLAG_ZERO : FLAG_NONE;
			default:  code = FLAG_NONE;
		endcase
		for (int i = 0; i < MAX_FLAGS; i++) begin
			slot_n[i] = slot_q[i];
			if (CNT_W'(i) < flag_cnt_q && slot_q[i] == code) begin
				hit = 1'b1;
			end
		end
		flag_cnt_n = flag_cnt_q;
		if (code != FLAG_NONE && !hit && flag_cnt_q < CNT_W'(MAX_FLAGS)) begin
			for (int i = 0; i < MAX_FLAGS; i++) begin
				if (CNT_W'(i) == flag_cnt_q) begin
					slot_n[i] = code;
				end
			end
			flag_cnt_n = flag_cnt_q + 1'b1;
		end

		// width: a dot starts skipping, the first non-digit after it is passed over
		skip_n      = skip_q;
		width_acc_n = width_acc_q;
		if (skip_q) begin
			if (!dig) begin
				skip_n = 1'b0;
			end
		end else if (c == CH_DOT) begin
			skip_n = 1'b1;
		end else if (dig) begin
			width_acc_n = pdig ? acc_digit(width_acc_q, c) : NUM_BITS'(c[3:0]);
		end

		// precision
		prec_on_n  = prec_on_q;
		prec_acc_n = prec_acc_q;
		if (c == CH_DOT) begin
			prec_on_n  = 1'b1;
			prec_acc_n = '0;
		end else if (prec_on_q && dig) begin
			prec_acc_n = acc_digit(prec_acc_q, c);
		end else begin
			prec_on_n = 1'b0;
		end

		// length modifier
		len_n = len_q;
		if (c == CH_LO_L && prev_q == CH_LO_L) begin
			len_n = LEN_LL;
		end else if (c == CH_LO_H && prev_q == CH_LO_H) begin
			len_n = LEN_HH;
		end else begin
			case (c)
				CH_LO_L: len_n = LEN_L;
				CH_LO_H: len_n = LEN_H;
				CH_LO_J: len_n = LEN_J;
				CH_LO_Z: len_n = LEN_Z;
				CH_LO_T: len_n = LEN_T;
				CH_UP_L: len_n = LEN_UL;
				default: len_n = len_q;
			endcase
		end

		prev_n = c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			flag_cnt_q  <= '0;
			width_acc_q <= '0;
			prec_acc_q  <= '0;
			prec_on_q   <= 1'b0;
			skip_q      <= 1'b0;
			len_q       <= LEN_NONE;
			out_v_q     <= 1'b0;
			for (int i = 0; i < MAX_FLAGS; i++) begin
				slot_q[i] <= FLAG_NONE;
			end
		end else begin
			// hold a pending result until taken, raise it on a last character
			out_v_q <= (accept && spec.data.last) || (out_v_q && !result.ready);
			if (accept) begin
				if (spec.data.last) begin
					// emit and clear the state for the next specifier
					prev_q      <= '0;
					flag_cnt_q  <= '0;
					width_acc_q <= '0;
					prec_acc_q  <= '0;
					prec_on_q   <= 1'b0;
					skip_q      <= 1'b0;
					len_q       <= LEN_NONE;
					for (int i = 0; i < MAX_FLAGS; i++) begin
						slot_q[i] <= FLAG_NONE;
					end
				end else begin
					prev_q      <= prev_n;
					flag_cnt_q  <= flag_cnt_n;
					width_acc_q <= width_acc_n;
					prec_acc_q  <= prec_acc_n;
					prec_on_q   <= prec_on_n;
					skip_q      <= skip_n;
					len_q       <= len_n;
					for (int i = 0; i < MAX_FLAGS; i++) begin
						slot_q[i] <= slot_n[i];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && spec.data.last) begin
			out_q.flag_first  <= slot_n[0];
			out_q.flag_second <= slot_n[1];
			out_q.flag_third  <= slot_n[2];
			out_q.flag_fourth <= slot_n[3];
			out_q.flag_fifth  <= slot_n[4];
			out_q.field_width <= 16'(width_acc_n);
			out_q.precision   <= 16'(prec_acc_n);
			out_q.length_mod  <= len_n;
			out_q.conv_type   <= spec.data.ch;
		end
	end

`ifndef NO_ASSERTIONS
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		accept && spec.data.last |=> flag_cnt_q == '0 && width_acc_q == '0 && !skip_q)
		else $error("parse state not cleared after last character");

	a_flag_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		flag_cnt_q <= CNT_W'(MAX_FLAGS))
		else $error("flag count beyond slot count");

	a_no_result_mid_spec: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !spec.data.last && !out_v_q |=> !out_v_q)
		else $error("result raised without a last character");

	a_flags_packed: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (out_q.flag_first != FLAG_NONE || out_q.flag_second == FLAG_NONE)
			&& (out_q.flag_fourth != FLAG_NONE || out_q.flag_fifth == FLAG_NONE))
		else $error("flag slots not filled in order");

	a_len_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> out_q.length_mod <= LEN_HH)
		else $error("length modifier code out of range");
`endif

endmodule

// ----- sim/format_spec_field_parser_core_checker.sv -----
// Monitor, specifier parse predictor and result comparison for the specifier field parser.
module format_spec_field_parser_core_checker (
	input  logic        clk,
	input  logic        arst_n,
	fsp_spec_if         spec,
	fsp_result_if       result,
	output int unsigned errors,
	output int unsigned pending
);
	import fsp_pkg::*;

	logic [7:0]   prev_ch;
	logic [2:0]   flag_list [MAX_FLAGS];
	int unsigned  flag_cnt;
	logic [15:0]  width_run;
	logic [15:0]  prec_run;
	logic         prec_open;
	logic         width_skip;
	logic [3:0]   len_sel;
	result_beat_t specs_due [$];

	function automatic logic is_num(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic [15:0] append_digit(input logic [15:0] acc, input logic [7:0] c);
		int unsigned v;
		v = 32'(acc);
		v = v * 10 + c - CH_ZERO;
		return (v > SAT_MAX) ? SAT_MAX : v[15:0];
	endfunction

	task automatic clear_parse();
		prev_ch    = 8'd0;
		flag_cnt   = 0;
		width_run  = 16'd0;
		prec_run   = 16'd0;
		prec_open  = 1'b0;
		width_skip = 1'b0;
		len_sel    = LEN_NONE;
		for (int i = 0; i < MAX_FLAGS; i++) begin
			flag_list[i] = FLAG_NONE;
		end
	endtask

	task automatic add_flag_code(input logic [2:0] code);
		logic dup;
		dup = 1'b0;
		for (int i = 0; i < flag_cnt; i++) begin
			if (flag_list[i] == code)
				dup = 1'b1;
		end
		if (!dup && flag_cnt < MAX_FLAGS) begin
			flag_list[flag_cnt] = code;
			flag_cnt++;
		end
	endtask

	// Advance the running parse by one character; the last one closes the specifier.
	task automatic parse_char(input logic [7:0] c, input logic fin);
		logic         dig;
		logic         pdig;
		result_beat_t r;
		dig  = is_num(c);
		pdig = is_num(prev_ch);

		if (c == CH_MINUS)
			add_flag_code(FLAG_MINUS);
		else if (c == CH_PLUS)
			add_flag_code(FLAG_PLUS);
		else if (c == CH_SPACE)
			add_flag_code(FLAG_SPACE);
		else if (c == CH_HASH)
			add_flag_code(FLAG_HASH);
		else if (c == CH_ZERO && !pdig && prev_ch != CH_DOT)
			add_flag_code(FLAG_ZERO);

		// the first non-digit after a dot's digits is passed over, even a dot
		if (width_skip) begin
			if (!dig)
				width_skip = 1'b0;
		end else if (c == CH_DOT) begin
			width_skip = 1'b1;
		end else if (dig) begin
			width_run = pdig ? append_digit(width_run, c) : 16'(c - CH_ZERO);
		end

		if (c == CH_DOT) begin
			prec_open = 1'b1;
			prec_run  = 16'd0;
		end else if (prec_open && dig) begin
			prec_run = append_digit(prec_run, c);
		end else begin
			prec_open = 1'b0;
		end

		if (c == CH_LO_L && prev_ch == CH_LO_L)
			len_sel = LEN_LL;
		else if (c == CH_LO_H && prev_ch == CH_LO_H)
			len_sel = LEN_HH;
		else if (c == CH_LO_L)
			len_sel = LEN_L;
		else if (c == CH_LO_H)
			len_sel = LEN_H;
		else if (c == CH_LO_J)
			len_sel = LEN_J;
		else if (c == CH_LO_Z)
			len_sel = LEN_Z;
		else if (c == CH_LO_T)
			len_sel = LEN_T;
		else if (c == CH_UP_L)
			len_sel = LEN_UL;

		prev_ch = c;

		if (fin) begin
			r.flag_first  = flag_list[0];
			r.flag_second = flag_list[1];
			r.flag_third  = flag_list[2];
			r.flag_fourth = flag_list[3];
			r.flag_fifth  = flag_list[4];
			r.field_width = width_run;
			r.precision   = prec_run;
			r.length_mod  = len_sel;
			r.conv_type   = c;
			specs_due.push_back(r);
			clear_parse();
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	task automatic check_result(input result_beat_t got);
		result_beat_t want;
		if (specs_due.size() == 0) begin
			$error("result beat with nothing outstanding, conv_type %0d", got.conv_type);
			errors++;
		end else begin
			want = specs_due.pop_front();
			check_field("flag_first", 16'(want.flag_first), 16'(got.flag_first));
			check_field("flag_second", 16'(want.flag_second), 16'(got.flag_second));
			check_field("flag_third", 16'(want.flag_third), 16'(got.flag_third));
			check_field("flag_fourth", 16'(want.flag_fourth), 16'(got.flag_fourth));
			check_field("flag_fifth", 16'(want.flag_fifth), 16'(got.flag_fifth));
			check_field("field_width", want.field_width, got.field_width);
			check_field("precision", want.precision, got.precision);
			check_field("length_mod", 16'(want.length_mod), 16'(got.length_mod));
			check_field("conv_type", 16'(want.conv_type), 16'(got.conv_type));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parse();
			specs_due.delete();
			errors  = 0;
			pending = 0;
		end else begin
			// drain first: a result taken this edge belongs to an earlier specifier
			if (result.valid && result.ready)
				check_result(result.data);
			if (spec.valid && spec.ready)
				parse_char(spec.data.ch, spec.data.last);
			pending = specs_due.size();
		end
	end

endmodule

// ----- sim/format_spec_field_parser_core_tb.sv -----
// Stimulus, handshake pacing and verdict for the specifier field parser.
module format_spec_field_parser_core_tb;
	import fsp_pkg::*;

	localparam int unsigned CHAR_TARGET = 1150;
	localparam int unsigned IDLE_LIMIT  = 5000;
	localparam int unsigned LONG_HOLD   = 150;

	logic        clk;
	logic        arst_n;
	int unsigned errors;
	int unsigned pending;
	int unsigned chars_sent = 0;
	int unsigned burst_left = 0;
	int unsigned idle_cycles = 0;
	bit          hold_req = 1'b0;

	string flag_set = "-+ #0";
	string conv_set = "diouxXfFeEgGaAcspn%";
	string mod_set  = "-+ #lhjztL";

	fsp_spec_if   spec_ch ();
	fsp_result_if result_ch ();

	format_spec_field_parser_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.spec   (spec_ch),
		.result (result_ch)
	);

	format_spec_field_parser_core_checker parse_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.spec    (spec_ch),
		.result  (result_ch),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Receiver: phases of always ready, random stalls and a periodic stall,
	// plus one long hold on request.
	initial begin
		int unsigned phase_left;
		int unsigned mode;
		int unsigned tick;
		int unsigned hold_left;
		phase_left = 0;
		mode       = 0;
		tick       = 0;
		hold_left  = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && hold_left == 0) begin
				hold_left = LONG_HOLD;
				hold_req  = 1'b0;
			end
			if (phase_left == 0) begin
				mode       = $urandom_range(0, 2);
				phase_left = $urandom_range(20, 80);
			end
			phase_left--;
			tick++;
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				case (mode)
					0: result_ch.ready <= 1'b1;
					1: result_ch.ready <= ($urandom_range(0, 3) != 0);
					default: result_ch.ready <= (tick % 5 != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((spec_ch.valid && spec_ch.ready) || (result_ch.valid && result_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("format_spec_field_parser_core_tb: done, errors");
				$finish;
			end
		end
	end

	// Offer one beat and hold it until taken; bursts end in a random gap.
	task automatic send_char(input logic [7:0] c, input logic fin);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				spec_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		spec_ch.valid <= 1'b1;
		spec_ch.data  <= '{ch: c, last: fin};
		burst_left--;
		do @(posedge clk); while (!spec_ch.ready);
		chars_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_char(s[i], i == s.len() - 1);
		end
	endtask

	function automatic logic [7:0] rand_digit();
		return 8'(CH_ZERO + $urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] noise_char();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 8'($urandom);
			4, 5, 6: return rand_digit();
			7: return CH_DOT;
			default: return mod_set[$urandom_range(0, mod_set.len() - 1)];
		endcase
	endfunction

	// Mostly well-formed specifiers with random content, some with one or two stray
	// characters inserted, and some pure noise.
	task automatic send_random_spec();
		logic [7:0]  chars [$];
		int unsigned kind;
		int unsigned n;
		kind = $urandom_range(0, 99);
		if (kind < 85) begin
			n = $urandom_range(0, 3);
			repeat (n) chars.push_back(flag_set[$urandom_range(0, 4)]);
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 3);
			repeat (n) chars.push_back(rand_digit());
			if ($urandom_range(0, 1) == 1) begin
				chars.push_back(CH_DOT);
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 3);
				repeat (n) chars.push_back(rand_digit());
			end
			case ($urandom_range(0, 8))
				1: chars.push_back(CH_LO_L);
				2: begin
					chars.push_back(CH_LO_L);
					chars.push_back(CH_LO_L);
				end
				3: chars.push_back(CH_LO_H);
				4: begin
					chars.push_back(CH_LO_H);
					chars.push_back(CH_LO_H);
				end
				5: chars.push_back(CH_LO_J);
				6: chars.push_back(CH_LO_Z);
				7: chars.push_back(CH_LO_T);
				8: chars.push_back(CH_UP_L);
				default: ;
			endcase
			if (kind >= 75) begin
				n = $urandom_range(1, 2);
				repeat (n) chars.insert($urandom_range(0, chars.size()), noise_char());
			end
			chars.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom) :
				conv_set[$urandom_range(0, conv_set.len() - 1)]);
		end else begin
			n = $urandom_range(1, 10);
			repeat (n) chars.push_back(noise_char());
		end
		for (int i = 0; i < chars.size(); i++) begin
			send_char(chars[i], i == chars.size() - 1);
		end
	endtask

	initial begin
		bit held;
		bit drained;
		held    = 1'b0;
		drained = 1'b0;
		arst_n        = 1'b0;
		spec_ch.valid = 1'b0;
		spec_ch.data  = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// all five flags, width, precision, ll
		send_text("-+ #07.5llX");
		// saturated width, zero after digit and after dot, hh
		send_text("70000.0hhd");
		send_char(8'hff, 1'b0);
		send_char(8'h00, 1'b1);

		while (chars_sent < CHAR_TARGET) begin
			if (!held && chars_sent >= 300) begin
				held     = 1'b1;
				hold_req = 1'b1;
			end
			if (!drained && chars_sent >= 700) begin
				drained = 1'b1;
				@(negedge clk);
				spec_ch.valid <= 1'b0;
				while (pending != 0) @(negedge clk);
			end
			send_random_spec();
		end
		@(negedge clk);
		spec_ch.valid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("format_spec_field_parser_core_tb: done, clean");
		end else begin
			$display("format_spec_field_parser_core_tb: done, errors");
		end
		$finish;
	end

endmodule

// ----- files.f -----
sv/fsp_pkg.sv
sv/fsp_if.sv
sv/format_spec_field_parser_core.sv
sim/format_spec_field_parser_core_checker.sv
sim/format_spec_field_parser_core_tb.sv
